### sv/mfrb_pkg.sv
// Shared types, codes and constants of the monochrome rectangle blit frame store.
package mfrb_pkg;

   localparam int DEF_MAX_KITS_ACROSS = 8;
   localparam int DEF_MAX_KITS_DOWN   = 8;

   localparam int KITS_W    = 4;
   localparam int POS_W     = 6;
   localparam int DIM_W     = 7;
   localparam int PIX_W     = 8;
   localparam int BPR_W     = 4;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_SOURCE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_KITS_ACROSS = 1'b0,
      CSR_KITS_DOWN   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] read_byte;
      logic [BPR_W-1:0] bytes_per_row;
      logic [DIM_W-1:0] rows_to_send;
      logic             paint_done;
      logic             status;
   } result_type;

   // leftmost n pixels of a byte, n from 1 to 8
   function automatic logic [PIX_W-1:0] lead_mask(input logic [BPR_W-1:0] n);
      lead_mask = ~(8'hFF >> n);
   endfunction

endpackage

### sv/mfrb_ram.sv
// Generic single-port synchronous RAM with registered read data.
module mfrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/mono_frame_rect_blit.sv
// Top level of the monochrome tiled frame store with rectangle blit.
//
//   port group | role     | transfer carries
//   req_*      | slave    | command in tuser, rectangle / source byte in tdata
//   rsp_*      | master   | read byte and paint geometry in tdata, done in tlast, status in tuser
//   csr_*      | write    | kits_across (index 0), kits_down (index 1)
//
// Begin and rejected items finish in ST_IDLE, a screen read goes on to ST_RDOUT, and a source
// byte runs ST_WR0 when it lands in one screen byte and ST_WR0, ST_RD1, ST_WR1 when it
// straddles two: every read-modify-write goes through the single port of the screen RAM.
// Clear sweeps the whole RAM, one byte a cycle; the same sweep runs after reset with
// req_tready low. While a result waits on rsp_tready the next item still runs, then
// holds its result with req_tready low until the result slot frees.
module mono_frame_rect_blit #(
   parameter int MAX_KITS_ACROSS = mfrb_pkg::DEF_MAX_KITS_ACROSS,
   parameter int MAX_KITS_DOWN   = mfrb_pkg::DEF_MAX_KITS_DOWN
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // x_pos[5:0], y_pos[11:6], rect_width[18:12], rect_height[25:19], source_byte[33:26]
   input  logic [mfrb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command[1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_byte[7:0], bytes_per_row[11:8], rows_to_send[18:12]
   output logic [mfrb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // status[0]
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [mfrb_pkg::KITS_W-1:0]        csr_wdata
);

   import mfrb_pkg::*;

   localparam int STORE_ROWS = MAX_KITS_DOWN * 8;
   localparam int STORE_SIZE = MAX_KITS_ACROSS * STORE_ROWS;
   localparam int AW         = $clog2(STORE_SIZE);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_WR0,
      ST_RD1,
      ST_WR1,
      ST_RDOUT,
      ST_HOLD
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              clr_cmd_ff, clr_cmd_in;
   logic [KITS_W-1:0] kits_across_ff, kits_across_in;
   logic [KITS_W-1:0] kits_down_ff, kits_down_in;

   logic              paint_active_ff, paint_active_in;
   logic [2:0]        bit_offset_ff, bit_offset_in;
   logic [2:0]        start_column_ff, start_column_in;
   logic [DIM_W-1:0]  clipped_width_ff, clipped_width_in;
   logic [BPR_W-1:0]  bytes_per_row_ff, bytes_per_row_in;
   logic [DIM_W-1:0]  row_cursor_ff, row_cursor_in;
   logic [DIM_W-1:0]  rows_left_ff, rows_left_in;
   logic [BPR_W-1:0]  byte_cursor_ff, byte_cursor_in;

   logic [AW-1:0]     addr0_ff, addr0_in;
   logic [AW-1:0]     addr1_ff, addr1_in;
   logic [PIX_W-1:0]  val0_ff, val0_in;
   logic [PIX_W-1:0]  mask0_ff, mask0_in;
   logic [PIX_W-1:0]  val1_ff, val1_in;
   logic [PIX_W-1:0]  mask1_ff, mask1_in;
   logic              wr1_ff, wr1_in;
   result_type        res_ff, res_in;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_res_ff, rsp_res_in;

   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   logic [PIX_W-1:0]  mem_wdata;
   logic [PIX_W-1:0]  mem_rdata;

   logic              done_now;
   result_type        res_now;

   cmd_type           in_cmd;
   logic [POS_W-1:0]  in_x, in_y;
   logic [DIM_W-1:0]  in_w, in_h;
   logic [PIX_W-1:0]  in_src;
   logic              accept;

   logic [KITS_W-1:0] eff_across, eff_down;
   logic [DIM_W-1:0]  scr_w, scr_h;
   logic              x_fits, y_fits;
   logic [DIM_W-1:0]  w_sat, h_sat, room_w, room_h, w_clip, h_clip;
   logic [BPR_W-1:0]  bpr_new;

   logic [DIM_W-1:0]  rem;
   logic [BPR_W-1:0]  n_bits;
   logic [PIX_W-1:0]  src_mask, src_data;
   logic [15:0]       sh_data, sh_mask;
   logic [5:0]        col0, col1, rd_col;
   logic              row_ok, wr0_ok, wr1_ok, rd_ok;
   logic [BPR_W-1:0]  bc_next;
   logic              slot_free;

   function automatic logic [AW-1:0] addr_of(input logic [DIM_W-1:0] row,
                                             input logic [5:0] col);
      logic [AW+7:0] full;
      full = (AW+8)'(row) * (AW+8)'(MAX_KITS_ACROSS) + (AW+8)'(col);
      return full[AW-1:0];
   endfunction

   mfrb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_SIZE)
   ) u_screen (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign in_cmd = cmd_type'(req_tuser);
   assign in_x   = req_tdata[5:0];
   assign in_y   = req_tdata[11:6];
   assign in_w   = req_tdata[18:12];
   assign in_h   = req_tdata[25:19];
   assign in_src = req_tdata[33:26];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign eff_across = (kits_across_ff == '0) ? KITS_W'(1) :
                       ({2'b00, kits_across_ff} > 6'(MAX_KITS_ACROSS)) ?
                       KITS_W'(MAX_KITS_ACROSS) : kits_across_ff;
   assign eff_down   = (kits_down_ff == '0) ? KITS_W'(1) :
                       ({2'b00, kits_down_ff} > 6'(MAX_KITS_DOWN)) ?
                       KITS_W'(MAX_KITS_DOWN) : kits_down_ff;
   assign scr_w = {eff_across, 3'b000};
   assign scr_h = {eff_down, 3'b000};

   assign x_fits = {1'b0, in_x} < scr_w;
   assign y_fits = {1'b0, in_y} < scr_h;
   assign w_sat  = (in_w > 7'd64) ? 7'd64 : in_w;
   assign h_sat  = (in_h > 7'd64) ? 7'd64 : in_h;
   assign room_w = scr_w - {1'b0, in_x};
   assign room_h = scr_h - {1'b0, in_y};
   assign w_clip = (w_sat > room_w) ? room_w : w_sat;
   assign h_clip = (h_sat > room_h) ? room_h : h_sat;
   assign bpr_new = BPR_W'(({1'b0, w_clip} + 8'd7) >> 3);

   assign rem      = clipped_width_ff - {byte_cursor_ff[3:0], 3'b000};
   assign n_bits   = (rem >= 7'd8) ? 4'd8 : rem[3:0];
   assign src_mask = lead_mask(n_bits);
   assign src_data = in_src & src_mask;
   assign sh_data  = {src_data, 8'h00} >> bit_offset_ff;
   assign sh_mask  = {src_mask, 8'h00} >> bit_offset_ff;
   assign col0     = {3'b000, start_column_ff} + {2'b00, byte_cursor_ff};
   assign col1     = col0 + 6'd1;
   assign row_ok   = {2'b00, row_cursor_ff} < 9'(STORE_ROWS);
   assign wr0_ok   = row_ok && (col0 < 6'(MAX_KITS_ACROSS));
   assign wr1_ok   = row_ok && (bit_offset_ff != 3'd0) && (col1 < 6'(MAX_KITS_ACROSS)) &&
                     (sh_mask[7:0] != 8'h00);
   assign bc_next  = byte_cursor_ff + 4'd1;

   assign rd_col = {3'b000, in_x[5:3]};
   assign rd_ok  = ({3'b000, in_y} < 9'(STORE_ROWS)) && (rd_col < 6'(MAX_KITS_ACROSS));

   always_comb begin
      state_in         = state_ff;
      sweep_in         = sweep_ff;
      clr_cmd_in       = clr_cmd_ff;
      kits_across_in   = kits_across_ff;
      kits_down_in     = kits_down_ff;
      paint_active_in  = paint_active_ff;
      bit_offset_in    = bit_offset_ff;
      start_column_in  = start_column_ff;
      clipped_width_in = clipped_width_ff;
      bytes_per_row_in = bytes_per_row_ff;
      row_cursor_in    = row_cursor_ff;
      rows_left_in     = rows_left_ff;
      byte_cursor_in   = byte_cursor_ff;
      addr0_in         = addr0_ff;
      addr1_in         = addr1_ff;
      val0_in          = val0_ff;
      mask0_in         = mask0_ff;
      val1_in          = val1_ff;
      mask1_in         = mask1_ff;
      wr1_in           = wr1_ff;
      res_in           = res_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_res_in       = rsp_res_ff;
      mem_we           = 1'b0;
      mem_addr         = addr0_ff;
      mem_wdata        = (mem_rdata & ~mask0_ff) | (val0_ff & mask0_ff);
      done_now         = 1'b0;
      res_now          = '0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_KITS_ACROSS: kits_across_in = csr_wdata;
            CSR_KITS_DOWN:   kits_down_in   = csr_wdata;
            default:         kits_across_in = kits_across_ff;
         endcase
      end

      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == AW'(STORE_SIZE - 1)) begin
               sweep_in = '0;
               if (clr_cmd_ff) begin
                  clr_cmd_in = 1'b0;
                  done_now   = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_IDLE: begin
            if (accept) begin
               case (in_cmd)
                  CMD_BEGIN: begin
                     paint_active_in = 1'b0;
                     done_now        = 1'b1;
                     if (!x_fits || !y_fits || in_w == '0 || in_h == '0) begin
                        res_now.status = 1'b1;
                     end else begin
                        paint_active_in  = 1'b1;
                        bit_offset_in    = in_x[2:0];
                        start_column_in  = in_x[5:3];
                        clipped_width_in = w_clip;
                        bytes_per_row_in = bpr_new;
                        row_cursor_in    = {1'b0, in_y};
                        rows_left_in     = h_clip;
                        byte_cursor_in   = '0;
                        res_now.bytes_per_row = bpr_new;
                        res_now.rows_to_send  = h_clip;
                     end
                  end

                  CMD_SOURCE: begin
                     if (!paint_active_ff) begin
                        done_now       = 1'b1;
                        res_now.status = 1'b1;
                     end else begin
                        addr0_in = addr_of(row_cursor_ff, col0);
                        addr1_in = addr_of(row_cursor_ff, col1);
                        val0_in  = sh_data[15:8];
                        mask0_in = sh_mask[15:8];
                        val1_in  = sh_data[7:0];
                        mask1_in = sh_mask[7:0];
                        wr1_in   = wr1_ok;
                        mem_addr = addr_of(row_cursor_ff, col0);
                        byte_cursor_in = bc_next;
                        res_in = '0;
                        if (bc_next >= bytes_per_row_ff) begin
                           byte_cursor_in = '0;
                           row_cursor_in  = row_cursor_ff + 7'd1;
                           rows_left_in   = rows_left_ff - 7'd1;
                           if (rows_left_ff == 7'd1) begin
                              paint_active_in   = 1'b0;
                              res_in.paint_done = 1'b1;
                           end
                        end
                        if (wr0_ok) begin
                           state_in = ST_WR0;
                        end else if (wr1_ok) begin
                           state_in = ST_RD1;
                        end else begin
                           done_now = 1'b1;
                           res_now  = res_in;
                        end
                     end
                  end

                  CMD_READ: begin
                     res_in = '0;
                     if (!x_fits || !y_fits) begin
                        done_now       = 1'b1;
                        res_now.status = 1'b1;
                     end else if (rd_ok) begin
                        mem_addr = addr_of({1'b0, in_y}, rd_col);
                        state_in = ST_RDOUT;
                     end else begin
                        done_now = 1'b1;
                     end
                  end

                  CMD_CLEAR: begin
                     clr_cmd_in = 1'b1;
                     sweep_in   = '0;
                     state_in   = ST_SWEEP;
                  end

                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_WR0: begin
            mem_we    = 1'b1;
            mem_addr  = addr0_ff;
            mem_wdata = (mem_rdata & ~mask0_ff) | (val0_ff & mask0_ff);
            if (wr1_ff) begin
               state_in = ST_RD1;
            end else begin
               done_now = 1'b1;
               res_now  = res_ff;
            end
         end

         ST_RD1: begin
            mem_addr = addr1_ff;
            state_in = ST_WR1;
         end

         ST_WR1: begin
            mem_we    = 1'b1;
            mem_addr  = addr1_ff;
            mem_wdata = (mem_rdata & ~mask1_ff) | (val1_ff & mask1_ff);
            done_now  = 1'b1;
            res_now   = res_ff;
         end

         ST_RDOUT: begin
            done_now          = 1'b1;
            res_now           = '0;
            res_now.read_byte = mem_rdata;
         end

         ST_HOLD: begin
            done_now = 1'b1;
            res_now  = res_ff;
         end

         default: state_in = ST_IDLE;
      endcase

      if (done_now) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = res_now;
            state_in     = ST_IDLE;
         end else begin
            res_in   = res_now;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_SWEEP;
         sweep_ff         <= '0;
         clr_cmd_ff       <= 1'b0;
         kits_across_ff   <= KITS_W'(8);
         kits_down_ff     <= KITS_W'(8);
         paint_active_ff  <= 1'b0;
         bit_offset_ff    <= '0;
         start_column_ff  <= '0;
         clipped_width_ff <= '0;
         bytes_per_row_ff <= '0;
         row_cursor_ff    <= '0;
         rows_left_ff     <= '0;
         byte_cursor_ff   <= '0;
         wr1_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         sweep_ff         <= sweep_in;
         clr_cmd_ff       <= clr_cmd_in;
         kits_across_ff   <= kits_across_in;
         kits_down_ff     <= kits_down_in;
         paint_active_ff  <= paint_active_in;
         bit_offset_ff    <= bit_offset_in;
         start_column_ff  <= start_column_in;
         clipped_width_ff <= clipped_width_in;
         bytes_per_row_ff <= bytes_per_row_in;
         row_cursor_ff    <= row_cursor_in;
         rows_left_ff     <= rows_left_in;
         byte_cursor_ff   <= byte_cursor_in;
         wr1_ff           <= wr1_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      addr0_ff   <= addr0_in;
      addr1_ff   <= addr1_in;
      val0_ff    <= val0_in;
      mask0_ff   <= mask0_in;
      val1_ff    <= val1_in;
      mask1_ff   <= mask1_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_res_ff.rows_to_send, rsp_res_ff.bytes_per_row,
                        rsp_res_ff.read_byte};
   assign rsp_tlast  = rsp_res_ff.paint_done;
   assign rsp_tuser  = rsp_res_ff.status;

endmodule
